### rtl/core/elementary_cellular_automaton_ring_macros.svh
// Assertion macros for the cellular automaton ring.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ELEMENTARY_CELLULAR_AUTOMATON_RING_MACROS_SVH
`define ELEMENTARY_CELLULAR_AUTOMATON_RING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ECA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ECA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/eca_pkg.sv
// Shared types and constants for the cellular automaton ring.
// No dependencies; imported by the controller, datapath and top level.
package eca_pkg;

  localparam int CELLS_DEF       = 256;
  localparam int RULE_W          = 8;
  localparam int SEED_W          = 8;
  localparam int LIVE_W          = 9;
  localparam int CHUNK_BITS      = 8;
  localparam int CHUNK_CNT_W     = 4;
  localparam int RESET_LIVE_CELL = 64;
  localparam logic [RULE_W-1:0] RESET_RULE = 8'd110;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_FLUSH
  } eca_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take an item: reseed if asked, advance one generation
    logic count;  // add one chunk of the new generation to the tally
    logic push;   // move the tally into the output register
  } eca_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;  // output register holds an item not taken this cycle
  } eca_sts_t;

  function automatic logic [CHUNK_CNT_W-1:0] popcnt_chunk(input logic [CHUNK_BITS-1:0] v);
    logic [CHUNK_CNT_W-1:0] sum;
    sum = '0;
    for (int b = 0; b < CHUNK_BITS; b++) begin
      sum = sum + CHUNK_CNT_W'(v[b]);
    end
    return sum;
  endfunction

endpackage

### rtl/core/elementary_cellular_automaton_ring.sv
// Elementary cellular automaton ring, one result per input item.
// On accept the ring advances; ST_COUNT tallies it and ST_FLUSH loads the output register.
// A new item is taken only once the last tally is pushed; the live-cell tally adds 8 cells a cycle.
// Reset (rst_n low, synchronous): rule 110, only cell 64 live, no result pending.
// A finished result waits in the output register while the next item is taken.
module elementary_cellular_automaton_ring #(
  parameter int CELLS = eca_pkg::CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [eca_pkg::RULE_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [eca_pkg::SEED_W-1:0] in_seed,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [eca_pkg::LIVE_W-1:0] out_live_count
);
  import eca_pkg::*;

  `include "elementary_cellular_automaton_ring_macros.svh"

  eca_cmd_t cmd;
  eca_sts_t sts;

  eca_ctrl #(
    .CELLS (CELLS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  eca_dpath #(
    .CELLS (CELLS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_func        (in_func),
    .in_seed        (in_seed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_live_count (out_live_count)
  );

  `ECA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item accepted while a tally is running")
  `ECA_ASSERT_NOW(a_count_in_range, out_valid && (CELLS < 512), out_live_count <= CELLS, "live count exceeds ring size")

endmodule

### rtl/core/eca_ctrl.sv
// Controller for the cellular automaton ring: handshake, sequencing, chunk counter.
// Depends on eca_pkg for the state enum and command/status structs.
module eca_ctrl #(
  parameter int CELLS = eca_pkg::CELLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  eca_pkg::eca_sts_t sts,
  output eca_pkg::eca_cmd_t cmd
);
  import eca_pkg::*;

  localparam int NCHUNK = (CELLS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam logic [CNT_W-1:0] LAST_CHUNK = CNT_W'(NCHUNK - 1);

  eca_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] chunk_r, chunk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chunk_r <= '0;
    end else begin
      state_r <= state_nxt;
      chunk_r <= chunk_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    chunk_nxt = chunk_r;
    in_stall  = 1'b1;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          chunk_nxt = '0;
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.count = 1'b1;
        chunk_nxt = chunk_r + 1'b1;
        if (chunk_r == LAST_CHUNK) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // hold the tally until the output register frees up
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/eca_dpath.sv
// Datapath for the cellular automaton ring: cell row, rule register,
// chunked live-cell tally and output register. Depends on eca_pkg.
module eca_dpath #(
  parameter int CELLS = eca_pkg::CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  eca_pkg::eca_cmd_t          cmd,
  output eca_pkg::eca_sts_t          sts,
  input  logic                       cfg_wr_en,
  input  logic [eca_pkg::RULE_W-1:0] cfg_wr_data,
  input  logic                       in_func,
  input  logic [eca_pkg::SEED_W-1:0] in_seed,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [eca_pkg::LIVE_W-1:0] out_live_count
);
  import eca_pkg::*;

  localparam logic [CELLS-1:0] RESET_RING = {{(CELLS-1){1'b0}}, 1'b1} << RESET_LIVE_CELL;

  logic [RULE_W-1:0] rule_r;
  logic [CELLS-1:0]  ring_r;
  logic [CELLS-1:0]  tally_sr_r;
  logic [LIVE_W-1:0] acc_r;
  logic              out_valid_r;
  logic [LIVE_W-1:0] out_live_r;

  logic [CELLS-1:0]  seeded;
  logic [CELLS-1:0]  base;
  logic [CELLS-1:0]  gen_nxt;

  // Reseed: seed bit k lands in cell CELLS-1-k, all else cleared
  always_comb begin
    seeded = '0;
    for (int k = 0; k < SEED_W; k++) begin
      seeded[CELLS-1-k] = in_seed[k];
    end
    base = in_func ? seeded : ring_r;
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? CELLS - 1 : i - 1;
    localparam int RIGHT = (i == CELLS - 1) ? 0 : i + 1;
    assign gen_nxt[i] = rule_r[{base[LEFT], base[i], base[RIGHT]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r      <= RESET_RULE;
      ring_r      <= RESET_RING;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rule_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        ring_r <= gen_nxt;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Tally: copy of the new generation, drained one chunk per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tally_sr_r <= gen_nxt;
      acc_r      <= '0;
    end else if (cmd.count) begin
      tally_sr_r <= tally_sr_r >> CHUNK_BITS;
      acc_r      <= acc_r + LIVE_W'(popcnt_chunk(tally_sr_r[CHUNK_BITS-1:0]));
    end
    if (cmd.push) begin
      out_live_r <= acc_r;
    end
  end

  assign sts.out_busy   = out_valid_r && out_stall;
  assign out_valid      = out_valid_r;
  assign out_live_count = out_live_r;

endmodule

### bench/eca_ring_checker.sv
// Scoreboard for the cellular automaton ring: a bit-level ring predictor plus live-count check.
// Depends on eca_pkg for widths and reset constants; instantiated by the testbench top.
module eca_ring_checker #(
  parameter int CELLS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_seed,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [8:0]  out_live_count,
  output int          errors,
  output int          outstanding,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import eca_pkg::*;

  logic [CELLS-1:0]  ring;
  logic [RULE_W-1:0] rule_sel;
  logic [LIVE_W-1:0] live_q[$];

  initial begin
    errors = 0;
    checked = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 30) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  // Optionally reseed, then advance the ring one generation; returns the live count.
  function automatic logic [LIVE_W-1:0] advance_ring(input logic reseed,
                                                     input logic [SEED_W-1:0] pattern);
    logic [CELLS-1:0] nxt;
    logic [2:0]       nbhd;
    int unsigned      live;
    live = 0;
    if (reseed) begin
      ring = '0;
      for (int k = 0; k < SEED_W; k++) begin
        ring[CELLS-1-k] = pattern[k];
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      nbhd = {ring[(i + CELLS - 1) % CELLS], ring[i], ring[(i + 1) % CELLS]};
      nxt[i] = rule_sel[nbhd];
      live += nxt[i];
    end
    ring = nxt;
    return LIVE_W'(live);
  endfunction

  always @(posedge clk) begin : watch
    logic [LIVE_W-1:0] want;
    if (!rst_n) begin
      ring = '0;
      if (RESET_LIVE_CELL < CELLS) begin
        ring[RESET_LIVE_CELL % CELLS] = 1'b1;
      end
      rule_sel = RESET_RULE;
      live_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (live_q.size() == 0) begin
          report_mismatch($sformatf("item with no expectation, live_count %0d",
                                    out_live_count));
        end else begin
          want = live_q.pop_front();
          checked++;
          if (out_live_count !== want) begin
            report_mismatch($sformatf("live_count %0d, expected %0d", out_live_count, want));
          end
        end
      end
      if (in_valid && !in_stall) begin
        live_q.push_back(advance_ring(in_func, in_seed));
      end
      if (cfg_wr_en) begin
        rule_sel = cfg_wr_data;
      end
    end
    outstanding <= live_q.size();
  end

endmodule

### bench/elementary_cellular_automaton_ring_tb.sv
// Testbench top for the cellular automaton ring: clock, reset, rule writes and item traffic.
// Depends on eca_pkg, the ring RTL and eca_ring_checker, which does all prediction and checking.
module elementary_cellular_automaton_ring_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eca_pkg::*;

  localparam int   CYCLE_LIMIT   = 800_000;
  localparam int   SETTLE_CYCLES = CELLS_DEF / 8 + 8;
  localparam int   RANDOM_PHASES = 8;
  localparam int   PHASE_ITEMS   = 200;
  localparam logic FN_ADVANCE    = 1'b0;
  localparam logic FN_RESEED     = 1'b1;

  typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HALF, PACE_HEAVY} pace_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [RULE_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_func = FN_ADVANCE;
  logic [SEED_W-1:0] in_seed = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [LIVE_W-1:0] out_live_count;

  int errors, outstanding, checked;
  int cycles = 0;
  int n_items = 0;
  int n_reseeds = 0;
  int n_settings = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  elementary_cellular_automaton_ring #(.CELLS(CELLS_DEF)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_seed        (in_seed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_live_count (out_live_count)
  );

  eca_ring_checker #(.CELLS(CELLS_DEF)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_seed        (in_seed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_live_count (out_live_count),
    .errors         (errors),
    .outstanding    (outstanding),
    .checked        (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d live counts still due", cycles, outstanding);
      $display("elementary_cellular_automaton_ring_tb: errors");
      $finish;
    end
  end

  // Receiver: stall in stretches, each with its own density.
  initial begin : rx_pace
    pace_t mode;
    int    span;
    forever begin
      mode = pace_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          PACE_FREE:  out_stall <= 1'b0;
          PACE_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          PACE_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
          default:    out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Present one item and hold it until taken; leaves valid high for a following item.
  task automatic send_item(input logic func, input logic [SEED_W-1:0] seed);
    in_valid <= 1'b1;
    in_func  <= func;
    in_seed  <= seed;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (func == FN_RESEED) begin
      n_reseeds++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_rule(input logic [RULE_W-1:0] rule);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rule;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    logic [RULE_W-1:0] rule;
    int                sent, burst, gap;
    bit                paused;
    n_settings = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Run from the reset ring under the reset rule, then reseed with edge patterns.
    send_item(FN_ADVANCE, 8'hFF);
    send_item(FN_ADVANCE, 8'h00);
    send_item(FN_ADVANCE, 8'h00);
    send_item(FN_RESEED, 8'h00);
    send_item(FN_RESEED, 8'hFF);
    send_item(FN_ADVANCE, 8'h00);
    send_item(FN_RESEED, 8'h01);
    send_item(FN_RESEED, 8'h80);
    send_item(FN_RESEED, 8'hAA);
    send_item(FN_RESEED, 8'h55);
    send_item(FN_ADVANCE, 8'hFF);
    drain();
    write_rule(8'd255);
    send_item(FN_RESEED, 8'h00);
    send_item(FN_ADVANCE, 8'h00);
    drain();
    write_rule(8'd0);
    send_item(FN_RESEED, 8'hFF);
    send_item(FN_ADVANCE, 8'hFF);
    drain();
    write_rule(8'd90);
    send_item(FN_RESEED, 8'h01);
    repeat (3) send_item(FN_ADVANCE, 8'h00);
    drain();
    write_rule(8'd30);
    send_item(FN_RESEED, 8'h80);
    repeat (2) send_item(FN_ADVANCE, 8'h00);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1:       rule = 8'd0;
        4:       rule = 8'd255;
        7:       rule = RESET_RULE;
        default: rule = 8'($urandom_range(0, 255));
      endcase
      drain();
      write_rule(rule);
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
          send_item(($urandom_range(0, 5) == 0) ? FN_RESEED : FN_ADVANCE,
                    8'($urandom_range(0, 255)));
          sent++;
        end
        // Hold off once per phase until the pipeline is empty.
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          drain();
        end else if (p % 3 != 0) begin
          gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items (%0d reseeds) under %0d rule settings, rules 0 and 255 among them",
             n_items, n_reseeds, n_settings);
    $display("%0d live counts compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("elementary_cellular_automaton_ring_tb: clean");
    end else begin
      $display("elementary_cellular_automaton_ring_tb: errors");
    end
    $finish;
  end

endmodule
